FILE: hw/rtl/bcv_pkg.sv
// ----------------------------------------------------------------------------
// bcv_pkg
// Shared formats, configuration record and the 2^(2^-i) root table.
// ----------------------------------------------------------------------------
package bcv_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LOG_FRAC  = 24;
  localparam int unsigned MSB_W     = $clog2(VAL_W);
  localparam int unsigned LG_W      = MSB_W + 1 + LOG_FRAC;
  localparam int unsigned EXP_FRAC  = 30;

  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    REG_VISC_INF  = 3'd0,
    REG_TIME_CONST = 3'd1,
    REG_STRESS    = 3'd2,
    REG_POWER_IDX = 3'd3,
    REG_YASUDA    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] visc_inf;
    logic [VAL_W-1:0] time_const;
    logic [VAL_W-1:0] stress;
    logic [31:0]      power_idx;
    logic [30:0]      yasuda;
  } cfg_t;

  // payload that rides along the power units
  typedef struct packed {
    logic [VAL_W-1:0] nu0;
    logic [31:0]      expo;
    logic             sat;
    logic             xzero;
  } side_t;

  // Q2.30 entry 2^(2^-idx), each the floor square root of the one before
  function automatic logic [31:0] root_entry(input int unsigned idx);
    logic [63:0] cur;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    cur = 64'd1 << 31;
    for (int unsigned k = 1; k <= idx; k++) begin
      v = cur << 30;
      r = '0;
      b = 64'd1 << 62;
      for (int unsigned j = 0; j < 32; j++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      cur = r;
    end
    return cur[31:0];
  endfunction

endpackage

FILE: hw/rtl/bcv_front.sv
// ----------------------------------------------------------------------------
// bcv_front
// Scaled rate x and exponent (n-1)/a through two restoring divider lanes.
// ----------------------------------------------------------------------------
module bcv_front import bcv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  logic [VAL_W-1:0] nu0_i,
  input  logic [VAL_W-1:0] rate_i,
  output logic             valid_o,
  output logic [VAL_W-1:0] x_o,
  output side_t            side_o
);

  localparam int unsigned DIV_STAGES = 32;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t            xl;
    lane_t            el;
    logic [VAL_W-1:0] nu0;
    logic [VAL_W-1:0] xk;
    logic             ovf_x;
    logic             sat_k;
    logic             ovf_e;
    logic             nneg;
    logic             nzero;
  } fs_t;

  function automatic lane_t div_step(lane_t l, logic [31:0] den);
    logic [32:0] cat;
    logic [32:0] dif;
    lane_t       r;
    cat  = {l.rem, l.lo[31]};
    dif  = cat - {1'b0, den};
    r.lo = {l.lo[30:0], 1'b0};
    if (cat >= {1'b0, den}) begin
      r.rem = dif[31:0];
      r.quo = {l.quo[30:0], 1'b1};
    end else begin
      r.rem = cat[31:0];
      r.quo = {l.quo[30:0], 1'b0};
    end
    return r;
  endfunction

  // stage 0: products and numerator magnitude
  logic              v0_q;
  logic [63:0]       p_q, kp_q;
  logic [VAL_W-1:0]  nu0_q;
  logic [31:0]       absn_q;
  logic              nneg_q, nzero_q;
  logic [32:0]       num_d, negn_d;

  assign num_d  = {cfg_i.power_idx[31], cfg_i.power_idx} - (33'd1 << LOG_FRAC);
  assign negn_d = -num_d;

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= {32'b0, nu0_i} * {32'b0, rate_i};
      kp_q    <= {32'b0, cfg_i.time_const} * {32'b0, rate_i};
      nu0_q   <= nu0_i;
      nneg_q  <= num_d[32];
      nzero_q <= (num_d == '0);
      absn_q  <= num_d[32] ? negn_d[31:0] : num_d[31:0];
    end
  end

  // stage 1: divider setup and rate-times-k path
  fs_t         init_d;
  logic [64:0] ksum;
  logic [63:0] un;

  always_comb begin
    ksum          = {1'b0, kp_q} + (65'd1 << (FRAC_BITS - 1));
    un            = {32'b0, absn_q} << LOG_FRAC;
    init_d.nu0    = nu0_q;
    init_d.nneg   = nneg_q;
    init_d.nzero  = nzero_q;
    init_d.xl.rem = p_q[63:32];
    init_d.xl.lo  = p_q[31:0];
    init_d.xl.quo = '0;
    init_d.ovf_x  = (p_q[63:32] >= cfg_i.stress);
    init_d.el.rem = un[63:32];
    init_d.el.lo  = un[31:0];
    init_d.el.quo = '0;
    init_d.ovf_e  = (un[63:32] >= {1'b0, cfg_i.yasuda});
    init_d.sat_k  = ((ksum >> FRAC_BITS) > 65'(VAL_MAX));
    init_d.xk     = init_d.sat_k ? VAL_MAX : ksum[FRAC_BITS +: VAL_W];
  end

  logic fv_q [DIV_STAGES+1];
  fs_t  fs_q [DIV_STAGES+1];

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q[0] <= 1'b0;
    end else if (en_i) begin
      fv_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fs_q[0] <= init_d;
    end
  end

  for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
    fs_t step_d;
    always_comb begin
      step_d    = fs_q[gi];
      step_d.xl = div_step(fs_q[gi].xl, cfg_i.stress);
      step_d.el = div_step(fs_q[gi].el, {1'b0, cfg_i.yasuda});
    end
    always_ff @(posedge clk_i, negedge rst_ni) begin
      if (!rst_ni) begin
        fv_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        fv_q[gi+1] <= fv_q[gi];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fs_q[gi+1] <= step_d;
      end
    end
  end

  // final: rounding and clamps
  fs_t              fin;
  logic [32:0]      qx, qe;
  logic [VAL_W-1:0] x_d;
  logic [31:0]      expo_d;
  logic             sat_d;

  always_comb begin
    fin    = fs_q[DIV_STAGES];
    sat_d  = 1'b0;
    qx     = {1'b0, fin.xl.quo} + 33'({fin.xl.rem, 1'b0} >= {1'b0, cfg_i.stress});
    qe     = {1'b0, fin.el.quo} + 33'({fin.el.rem, 1'b0} >= {2'b0, cfg_i.yasuda});
    if (cfg_i.stress != '0) begin
      if (fin.ovf_x || qx[32]) begin
        x_d   = VAL_MAX;
        sat_d = 1'b1;
      end else begin
        x_d = qx[31:0];
      end
    end else begin
      x_d   = fin.xk;
      sat_d = fin.sat_k;
    end
    if (cfg_i.yasuda == '0) begin
      if (fin.nzero) begin
        expo_d = '0;
      end else begin
        sat_d  = 1'b1;
        expo_d = fin.nneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end else if (fin.nneg) begin
      if (fin.ovf_e || qe > 33'h0_8000_0000) begin
        sat_d  = 1'b1;
        expo_d = 32'h8000_0000;
      end else begin
        expo_d = -qe[31:0];
      end
    end else begin
      if (fin.ovf_e || qe > 33'h0_7FFF_FFFF) begin
        sat_d  = 1'b1;
        expo_d = 32'h7FFF_FFFF;
      end else begin
        expo_d = qe[31:0];
      end
    end
  end

  logic vo_q;

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= fv_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o          <= x_d;
      side_o.nu0   <= fin.nu0;
      side_o.expo  <= expo_d;
      side_o.sat   <= sat_d;
      side_o.xzero <= (x_d == '0);
    end
  end

  assign valid_o = vo_q;

endmodule

FILE: hw/rtl/bcv_log2.sv
// ----------------------------------------------------------------------------
// bcv_log2
// Pipelined log2: leading-one normalize, then one mantissa squaring a stage.
// ----------------------------------------------------------------------------
module bcv_log2 import bcv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [VAL_W-1:0]       base_i,
  input  logic [31:0]            y_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  output logic signed [LG_W-1:0] lg_o,
  output logic [31:0]            y_o,
  output side_t                  side_o
);

  typedef struct packed {
    logic [31:0]         m;
    logic [LOG_FRAC-1:0] frac;
    logic [MSB_W-1:0]    p;
    logic [31:0]         y;
    side_t               side;
  } ls_t;

  logic v_q [LOG_FRAC+1];
  ls_t  s_q [LOG_FRAC+1];

  ls_t              norm_d;
  logic [MSB_W-1:0] msb;

  always_comb begin
    msb = '0;
    for (int i = 0; i < VAL_W; i++) begin
      if (base_i[i]) begin
        msb = MSB_W'(i);
      end
    end
    norm_d.p    = msb;
    norm_d.m    = base_i << (MSB_W'(VAL_W - 1) - msb);
    norm_d.frac = '0;
    norm_d.y    = y_i;
    norm_d.side = side_i;
  end

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= norm_d;
    end
  end

  for (genvar gi = 0; gi < LOG_FRAC; gi++) begin : g_sq
    ls_t         sq_d;
    logic [63:0] prod;
    logic [32:0] t;
    always_comb begin
      prod      = {32'b0, s_q[gi].m} * {32'b0, s_q[gi].m};
      t         = prod[63:31];
      sq_d      = s_q[gi];
      sq_d.frac = {s_q[gi].frac[LOG_FRAC-2:0], t[32]};
      sq_d.m    = t[32] ? t[32:1] : t[31:0];
    end
    always_ff @(posedge clk_i, negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_q[gi];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[gi+1] <= sq_d;
      end
    end
  end

  logic [MSB_W:0] ipart;

  assign ipart   = {1'b0, s_q[LOG_FRAC].p} - (MSB_W+1)'(FRAC_BITS);
  assign lg_o    = {ipart, s_q[LOG_FRAC].frac};
  assign y_o     = s_q[LOG_FRAC].y;
  assign side_o  = s_q[LOG_FRAC].side;
  assign valid_o = v_q[LOG_FRAC];

endmodule

FILE: hw/rtl/bcv_exp2.sv
// ----------------------------------------------------------------------------
// bcv_exp2
// Pipelined y*log2 product and exp2: one root-table multiply a stage.
// ----------------------------------------------------------------------------
module bcv_exp2 import bcv_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [LG_W-1:0] lg_i,
  input  logic [31:0]            y_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  output logic [VAL_W-1:0]       pw_o,
  output logic                   pw_sat_o,
  output side_t                  side_o
);

  localparam int unsigned PROD_W = 32 + LG_W - 1;
  localparam int unsigned MAG_W  = PROD_W - LOG_FRAC + 1;
  localparam int unsigned IP_W   = MAG_W + 1 - LOG_FRAC;

  typedef struct packed {
    logic [31:0]         m;
    logic [IP_W-1:0]     ip;
    logic [LOG_FRAC-1:0] f;
    side_t               side;
  } es_t;

  // stage a: magnitude product
  logic              va_q;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  side_t             sa_q;
  logic [31:0]       my;
  logic [LG_W-1:0]   lgn;
  logic [LG_W-2:0]   ml;

  assign my  = y_i[31] ? -y_i : y_i;
  assign lgn = -lg_i;
  assign ml  = lg_i[LG_W-1] ? lgn[LG_W-2:0] : lg_i[LG_W-2:0];

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(my) * PROD_W'(ml);
      neg_q  <= y_i[31] ^ lg_i[LG_W-1];
      sa_q   <= side_i;
    end
  end

  // stage b: round, sign, split into integer and fraction
  es_t             split_d;
  logic [PROD_W:0] rsum;
  logic [MAG_W:0]  e;

  always_comb begin
    rsum         = {1'b0, prod_q} + ((PROD_W+1)'(1) << (LOG_FRAC - 1));
    e            = {1'b0, rsum[PROD_W:LOG_FRAC]};
    if (neg_q) begin
      e = -e;
    end
    split_d.ip   = e[MAG_W:LOG_FRAC];
    split_d.f    = e[LOG_FRAC-1:0];
    split_d.m    = 32'd1 << EXP_FRAC;
    split_d.side = sa_q;
  end

  logic v_q [LOG_FRAC+1];
  es_t  s_q [LOG_FRAC+1];

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= split_d;
    end
  end

  for (genvar gi = 0; gi < LOG_FRAC; gi++) begin : g_mul
    localparam logic [31:0] ROOT = root_entry(gi + 1);
    es_t         mul_d;
    logic [63:0] prod;
    always_comb begin
      prod  = {32'b0, s_q[gi].m} * {32'b0, ROOT} + (64'd1 << (EXP_FRAC - 1));
      mul_d = s_q[gi];
      if (s_q[gi].f[LOG_FRAC-1-gi]) begin
        mul_d.m = prod[EXP_FRAC +: 32];
      end
    end
    always_ff @(posedge clk_i, negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi+1] <= 1'b0;
      end else if (en_i) begin
        v_q[gi+1] <= v_q[gi];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[gi+1] <= mul_d;
      end
    end
  end

  // final: shift into value format
  es_t              fin;
  logic [15:0]      sh;
  logic [15:0]      sr;
  logic [63:0]      w;
  logic [VAL_W-1:0] pw_d;
  logic             sat_d;

  always_comb begin
    fin   = s_q[LOG_FRAC];
    sh    = {{(16-IP_W){fin.ip[IP_W-1]}}, fin.ip} + 16'(FRAC_BITS) - 16'(EXP_FRAC);
    sr    = -sh;
    w     = '0;
    pw_d  = '0;
    sat_d = 1'b0;
    if (!sh[15]) begin
      if (sh > 16'd32) begin
        pw_d  = VAL_MAX;
        sat_d = 1'b1;
      end else begin
        w = {32'b0, fin.m} << sh[5:0];
        if (w[63:32] != '0) begin
          pw_d  = VAL_MAX;
          sat_d = 1'b1;
        end else begin
          pw_d = w[31:0];
        end
      end
    end else if (sr < 16'd40) begin
      w    = ({32'b0, fin.m} + (64'd1 << (sr[5:0] - 6'd1))) >> sr[5:0];
      pw_d = w[31:0];
    end
  end

  logic vo_q;

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[LOG_FRAC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pw_o     <= pw_d;
      pw_sat_o <= sat_d;
      side_o   <= fin.side;
    end
  end

  assign valid_o = vo_q;

endmodule

FILE: hw/rtl/bird_carreau_viscosity.sv
// ----------------------------------------------------------------------------
// bird_carreau_viscosity
// Throughput: one cell per cycle; the whole pipeline advances together and
// holds while the output register waits on m_axis_tready.
// Reset clears all valid bits and loads the register defaults (a = 2.0).
// Stage depth is set by one 32-bit multiply or one divider bit per stage.
// ----------------------------------------------------------------------------
module bird_carreau_viscosity import bcv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // zero_shear_viscosity, strain_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // viscosity
  output logic        m_axis_tuser,   // saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic adv;
  logic out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.visc_inf   <= '0;
      cfg_q.time_const <= '0;
      cfg_q.stress     <= '0;
      cfg_q.power_idx  <= '0;
      cfg_q.yasuda     <= 31'd33554432;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_VISC_INF:   cfg_q.visc_inf   <= cfg_data_i;
        REG_TIME_CONST: cfg_q.time_const <= cfg_data_i;
        REG_STRESS:     cfg_q.stress     <= cfg_data_i;
        REG_POWER_IDX:  cfg_q.power_idx  <= cfg_data_i;
        REG_YASUDA:     cfg_q.yasuda     <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // scaled rate and exponent
  logic             fr_v;
  logic [VAL_W-1:0] fr_x;
  side_t            fr_side;

  bcv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .nu0_i   (s_axis_tdata[31:0]),
    .rate_i  (s_axis_tdata[63:32]),
    .valid_o (fr_v),
    .x_o     (fr_x),
    .side_o  (fr_side)
  );

  // x^a
  logic                   la_v;
  logic signed [LG_W-1:0] la_lg;
  logic [31:0]            la_y;
  side_t                  la_side;
  logic                   ea_v, ea_sat;
  logic [VAL_W-1:0]       ea_pw;
  side_t                  ea_side;

  bcv_log2 u_log2_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_v),
    .base_i  (fr_x),
    .y_i     ({1'b0, cfg_q.yasuda}),
    .side_i  (fr_side),
    .valid_o (la_v),
    .lg_o    (la_lg),
    .y_o     (la_y),
    .side_o  (la_side)
  );

  bcv_exp2 u_exp2_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (la_v),
    .lg_i     (la_lg),
    .y_i      (la_y),
    .side_i   (la_side),
    .valid_o  (ea_v),
    .pw_o     (ea_pw),
    .pw_sat_o (ea_sat),
    .side_o   (ea_side)
  );

  // base = 1 + x^a
  logic             bs_v_q;
  logic [VAL_W-1:0] bs_q;
  side_t            bs_side_q;
  logic [VAL_W-1:0] xa;
  logic [VAL_W:0]   bsum;
  side_t            bs_side_d;

  always_comb begin
    xa            = ea_side.xzero ? '0 : ea_pw;
    bsum          = {1'b0, xa} + {1'b0, VAL_ONE};
    bs_side_d     = ea_side;
    bs_side_d.sat = ea_side.sat | (ea_sat & !ea_side.xzero) | bsum[VAL_W];
  end

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      bs_v_q <= 1'b0;
    end else if (adv) begin
      bs_v_q <= ea_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bs_q      <= bsum[VAL_W] ? VAL_MAX : bsum[VAL_W-1:0];
      bs_side_q <= bs_side_d;
    end
  end

  // base^((n-1)/a)
  logic                   lb_v;
  logic signed [LG_W-1:0] lb_lg;
  logic [31:0]            lb_y;
  side_t                  lb_side;
  logic                   eb_v, eb_sat;
  logic [VAL_W-1:0]       eb_pw;
  side_t                  eb_side;

  bcv_log2 u_log2_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (bs_v_q),
    .base_i  (bs_q),
    .y_i     (bs_side_q.expo),
    .side_i  (bs_side_q),
    .valid_o (lb_v),
    .lg_o    (lb_lg),
    .y_o     (lb_y),
    .side_o  (lb_side)
  );

  bcv_exp2 u_exp2_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (lb_v),
    .lg_i     (lb_lg),
    .y_i      (lb_y),
    .side_i   (lb_side),
    .valid_o  (eb_v),
    .pw_o     (eb_pw),
    .pw_sat_o (eb_sat),
    .side_o   (eb_side)
  );

  // (nu0 - nuInf) * pw
  logic           mu_v_q, mu_neg_q, mu_sat_q;
  logic [63:0]    mu_q;
  logic [VAL_W:0] diff, ndiff;
  logic [31:0]    absd;

  assign diff  = {1'b0, eb_side.nu0} - {1'b0, cfg_q.visc_inf};
  assign ndiff = -diff;
  assign absd  = diff[VAL_W] ? ndiff[31:0] : diff[31:0];

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      mu_v_q <= 1'b0;
    end else if (adv) begin
      mu_v_q <= eb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mu_q     <= {32'b0, absd} * {32'b0, eb_pw};
      mu_neg_q <= diff[VAL_W];
      mu_sat_q <= eb_side.sat | eb_sat;
    end
  end

  // round, add nuInf, clamp into the output register
  logic [64:0]      rsum;
  logic [49:0]      res;
  logic [VAL_W-1:0] vis_d;
  logic             sat_d;
  logic [31:0]      vis_q;
  logic             sat_q;

  always_comb begin
    rsum  = {1'b0, mu_q} + (65'd1 << (FRAC_BITS - 1));
    res   = mu_neg_q ? ({18'b0, cfg_q.visc_inf} - 50'(rsum >> FRAC_BITS))
                     : ({18'b0, cfg_q.visc_inf} + 50'(rsum >> FRAC_BITS));
    sat_d = mu_sat_q;
    if (res[49]) begin
      vis_d = '0;
      sat_d = 1'b1;
    end else if (res[48:VAL_W] != '0) begin
      vis_d = VAL_MAX;
      sat_d = 1'b1;
    end else begin
      vis_d = res[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i, negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= mu_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= vis_d;
      sat_q <= sat_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = vis_q;
  assign m_axis_tuser  = sat_q;

endmodule
